// File: src/sseq_pkg.sv
// ----------------------------------------------------------------------------
// sseq_pkg: shared constants and types of the stereo equalizer
// Number formats, store geometry, operation codes and the control bundle that
// the sequencer hands to the datapath and to the top level.
// ----------------------------------------------------------------------------
package sseq_pkg;

   // Filter geometry and number formats.
   localparam int BANDS          = 7;
   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_BITS      = 32;
   localparam int COEF_FRAC_BITS = 28;
   localparam int DELAY_FRAC     = 16;
   localparam int DELAY_BITS     = 48;
   localparam int GAIN_BITS      = 31;
   localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
   localparam int PROD_SHIFT     = COEF_FRAC_BITS - DELAY_FRAC;

   // Input field widths.
   localparam int COEF_BAND_BITS = 3;
   localparam int COEF_SLOT_BITS = 3;

   // Five coefficients per band: b0, b1, b2, a1, a2.
   localparam int NUM_SLOTS  = 5;
   localparam int COEF_DEPTH = BANDS * NUM_SLOTS;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   // Two delay words per band and channel.
   localparam int DLY_DEPTH  = 2 * BANDS * 2;
   localparam int DLY_AW     = $clog2(DLY_DEPTH);
   localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;

   // Unity gain in unsigned Q3.28.
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1) << COEF_FRAC_BITS;

   // Operation field of an input beat.
   localparam logic OPER_SAMPLE = 1'b0;
   localparam logic OPER_COEF   = 1'b1;

   // Configuration register indexes.
   localparam int CSR_IDX_BITS = 2;
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_EQ_ENABLE,
      CSR_MONO_MODE,
      CSR_OUTPUT_GAIN
   } csr_idx_type;

   // One multiply step of the shared MAC. The biquad steps follow the
   // coefficient slot order, so their code doubles as the slot index.
   typedef enum logic [2:0] {
      OP_B0,
      OP_B1,
      OP_B2,
      OP_A1,
      OP_A2,
      OP_GAIN
   } op_type;

   typedef struct packed {
      logic                idle;
      logic                coef_re;
      logic [COEF_AW-1:0]  coef_raddr;
      logic                load_y;
      logic                load_ch;
      logic                dly_re;
      logic [DLY_AW-1:0]   dly_raddr;
      logic                s1_gain;
      logic                s2_vld;
      op_type              s2_op;
      logic                s2_ch;
      logic                dly_we;
      logic [DLY_AW-1:0]   dly_waddr;
      logic                out_load;
   } ctl_type;

endpackage

// File: src/sseq_req_if.sv
// ----------------------------------------------------------------------------
// sseq_req_if: input channel of the stereo equalizer
// Carries sample pairs and coefficient writes with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sseq_req_if import sseq_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;
   logic [COEF_BAND_BITS-1:0]     coef_band;
   logic [COEF_SLOT_BITS-1:0]     coef_slot;
   logic signed [COEF_BITS-1:0]   coef_value;

   modport source (output valid, operation, left_sample, right_sample, coef_band,
                   coef_slot, coef_value, input ready);
   modport sink (input valid, operation, left_sample, right_sample, coef_band,
                 coef_slot, coef_value, output ready);
endinterface

// File: src/sseq_rsp_if.sv
// ----------------------------------------------------------------------------
// sseq_rsp_if: result channel of the stereo equalizer
// Carries one processed stereo pair per beat.
// ----------------------------------------------------------------------------
interface sseq_rsp_if import sseq_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink (input valid, left_out, right_out, output ready);
endinterface

// File: src/sseq_csr_if.sv
// ----------------------------------------------------------------------------
// sseq_csr_if: configuration write channel of the stereo equalizer
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sseq_csr_if import sseq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [GAIN_BITS-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: src/stereo_seven_band_biquad_eq.sv
// ----------------------------------------------------------------------------
// stereo_seven_band_biquad_eq: seven-band stereo biquad equalizer
// Cascaded transposed direct form II biquads per channel on one shared MAC,
// with coefficients and delay words held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Usage. The req_bus channel takes one beat per item: a sample pair
// (operation 0) or a coefficient write (operation 1, band and slot select the
// word; writes outside the table are dropped and return nothing). Each sample
// pair returns exactly one beat on rsp_bus. The csr_bus channel writes the
// enable, mono and output gain registers; it is always ready and is meant to be
// written only while the block is idle.
// Timing. A coefficient write leaves the block idle. With the filters
// enabled a pair runs 5*BANDS+1 MAC steps per channel, one per cycle, and
// the block becomes ready for the next beat in the same cycle that the
// result appears in the output register. The single multiplier, fed one
// coefficient per cycle from the coefficient RAM read port, sets that pace.
// In bypass a pair goes through the finish state to the output register.
// Reset. The synchronous reset clears the control registers and every valid bit
// of both stores, so all coefficients and delay words read zero until written.
// Stalls. A finished pair sits in the output register; while that register is
// still full the block holds its own result and does not accept a new beat.
// ----------------------------------------------------------------------------
module stereo_seven_band_biquad_eq import sseq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sseq_req_if.sink  req_bus,
   sseq_rsp_if.source rsp_bus,
   sseq_csr_if.sink  csr_bus
);
   // Configuration registers.
   logic                 eq_enable_ff;
   logic                 mono_mode_ff;
   logic [GAIN_BITS-1:0] output_gain_ff;

   // Output register.
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff;

   // Store valid bits: an entry not yet written reads as zero.
   logic [COEF_DEPTH-1:0] coef_valid_ff;
   logic [DLY_DEPTH-1:0]  dly_valid_ff;
   logic                  coef_ok_ff;
   logic                  dly_ok_ff;

   ctl_type                        ctl;
   logic                           req_acc;
   logic                           sample_start;
   logic                           coef_in_range;
   logic                           coef_we;
   logic [COEF_AW-1:0]             coef_waddr;
   logic [COEF_BITS-1:0]           coef_rdata;
   logic signed [COEF_BITS-1:0]    coef_q;
   logic [DELAY_BITS-1:0]          dly_rdata;
   logic signed [DELAY_BITS-1:0]   dly_q;
   logic signed [DELAY_BITS-1:0]   dly_wdata;
   logic signed [SAMPLE_BITS-1:0]  chan_l;
   logic signed [SAMPLE_BITS-1:0]  chan_r;
   logic                           out_free;

   assign req_bus.ready = ctl.idle;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign sample_start  = req_acc && (req_bus.operation == OPER_SAMPLE);

   assign coef_in_range = (int'(req_bus.coef_band) < BANDS) &&
                          (int'(req_bus.coef_slot) < NUM_SLOTS);
   assign coef_we       = req_acc && (req_bus.operation == OPER_COEF) && coef_in_range;
   assign coef_waddr    = COEF_AW'(int'(req_bus.coef_band) * NUM_SLOTS +
                                   int'(req_bus.coef_slot));

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Configuration writes are always accepted.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eq_enable_ff   <= 1'b0;
         mono_mode_ff   <= 1'b0;
         output_gain_ff <= GAIN_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_EQ_ENABLE:   eq_enable_ff   <= csr_bus.data[0];
            CSR_MONO_MODE:   mono_mode_ff   <= csr_bus.data[0];
            CSR_OUTPUT_GAIN: output_gain_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Valid bits ride along with each RAM read so that the masked data
   // lines up with the registered read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_valid_ff <= '0;
         dly_valid_ff  <= '0;
         coef_ok_ff    <= 1'b0;
         dly_ok_ff     <= 1'b0;
      end else begin
         if (coef_we) begin
            coef_valid_ff[coef_waddr] <= 1'b1;
         end
         if (ctl.dly_we) begin
            dly_valid_ff[ctl.dly_waddr] <= 1'b1;
         end
         if (ctl.coef_re) begin
            coef_ok_ff <= coef_valid_ff[ctl.coef_raddr];
         end
         if (ctl.dly_re) begin
            dly_ok_ff <= dly_valid_ff[ctl.dly_raddr];
         end
      end
   end

   assign coef_q = coef_ok_ff ? signed'(coef_rdata) : '0;
   assign dly_q  = dly_ok_ff ? signed'(dly_rdata) : '0;

   sseq_ram #(
      .WIDTH (COEF_BITS),
      .DEPTH (COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (req_bus.coef_value),
      .rd_en   (ctl.coef_re),
      .rd_addr (ctl.coef_raddr),
      .rd_data (coef_rdata)
   );

   sseq_ram #(
      .WIDTH (DELAY_BITS),
      .DEPTH (DLY_DEPTH)
   ) u_dly_ram (
      .clock   (clock),
      .wr_en   (ctl.dly_we),
      .wr_addr (ctl.dly_waddr),
      .wr_data (dly_wdata),
      .rd_en   (ctl.dly_re),
      .rd_addr (ctl.dly_raddr),
      .rd_data (dly_rdata)
   );

   sseq_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .sample_start (sample_start),
      .eq_enable    (eq_enable_ff),
      .out_free     (out_free),
      .ctl          (ctl)
   );

   // The datapath keeps the accepted samples; in bypass they go out untouched.
   sseq_dp u_dp (
      .clock     (clock),
      .ctl       (ctl),
      .coef_q    (coef_q),
      .dly_q     (dly_q),
      .gain      (output_gain_ff),
      .smp_load  (sample_start),
      .left_in   (req_bus.left_sample),
      .right_in  (req_bus.right_sample),
      .dly_wdata (dly_wdata),
      .chan_l    (chan_l),
      .chan_r    (chan_r)
   );

   // Output register. Mono mode copies the left result onto the right side
   // whether or not the filters ran.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_left_ff  <= chan_l;
         rsp_right_ff <= mono_mode_ff ? chan_l : chan_r;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.left_out  = rsp_left_ff;
   assign rsp_bus.right_out = rsp_right_ff;

`ifndef SYNTHESIS
   a_coef_port_free: assert property (@(posedge clock) disable iff (reset)
      !(coef_we && ctl.coef_re))
      else $error("coefficient write during a filter run");

   a_load_after_drain: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> !ctl.s2_vld)
      else $error("result loaded while MAC steps are in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> (rsp_bus.valid &&
         $stable(rsp_bus.left_out) && $stable(rsp_bus.right_out)))
      else $error("result beat changed while the receiver stalled");
`endif
endmodule

// File: src/sseq_ram.sv
// ----------------------------------------------------------------------------
// sseq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sseq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/sseq_seq.sv
// ----------------------------------------------------------------------------
// sseq_seq: step sequencer of the stereo equalizer
// Issues one MAC step per cycle, walks bands and channels, and tracks each
// step through the read and multiply stages.
// ----------------------------------------------------------------------------
module sseq_seq import sseq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    sample_start,
   input  logic    eq_enable,
   input  logic    out_free,
   output ctl_type ctl
);
   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic              vld;
      op_type            op;
      logic [BAND_W-1:0] band;
      logic              ch;
   } tok_type;

   state_type         state_ff, state_in;
   logic              issue_ff, issue_in;
   op_type            op_ff, op_in;
   logic [BAND_W-1:0] band_ff, band_in;
   logic              ch_ff, ch_in;
   tok_type           tok0;
   tok_type           tok1_ff;
   tok_type           tok2_ff;

   function automatic logic [DLY_AW-1:0] dly_addr(input logic ch,
                                                   input logic [BAND_W-1:0] band,
                                                   input logic k);
      return DLY_AW'((int'(ch) * BANDS + int'(band)) * 2 + int'(k));
   endfunction

   always_comb begin
      tok0.vld  = (state_ff == S_RUN) && issue_ff;
      tok0.op   = op_ff;
      tok0.band = band_ff;
      tok0.ch   = ch_ff;

      state_in = state_ff;
      issue_in = issue_ff;
      op_in    = op_ff;
      band_in  = band_ff;
      ch_in    = ch_ff;

      // Step order per channel: five biquad steps per band, then the gain.
      if (tok0.vld) begin
         case (op_ff)
            OP_B0: op_in = OP_B1;
            OP_B1: op_in = OP_B2;
            OP_B2: op_in = OP_A1;
            OP_A1: op_in = OP_A2;
            OP_A2: begin
               if (band_ff == BAND_W'(BANDS - 1)) begin
                  op_in = OP_GAIN;
               end else begin
                  op_in   = OP_B0;
                  band_in = band_ff + 1'b1;
               end
            end
            OP_GAIN: begin
               if (!ch_ff) begin
                  ch_in   = 1'b1;
                  band_in = '0;
                  op_in   = OP_B0;
               end else begin
                  issue_in = 1'b0;
               end
            end
            default: issue_in = 1'b0;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (sample_start) begin
               if (eq_enable) begin
                  state_in = S_RUN;
                  issue_in = 1'b1;
                  op_in    = OP_B0;
                  band_in  = '0;
                  ch_in    = 1'b0;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_RUN: begin
            if (tok2_ff.vld && tok2_ff.op == OP_GAIN && tok2_ff.ch) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issue_ff <= 1'b0;
         op_ff    <= OP_B0;
         band_ff  <= '0;
         ch_ff    <= 1'b0;
         tok1_ff  <= '0;
         tok2_ff  <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         op_ff    <= op_in;
         band_ff  <= band_in;
         ch_ff    <= ch_in;
         tok1_ff  <= tok0;
         tok2_ff  <= tok1_ff;
      end
   end

   always_comb begin
      ctl.idle       = (state_ff == S_IDLE);
      ctl.coef_re    = tok0.vld && (tok0.op != OP_GAIN);
      ctl.coef_raddr = COEF_AW'(int'(tok0.band) * NUM_SLOTS + int'(tok0.op));
      ctl.load_y     = tok0.vld && (tok0.op == OP_B0) && (tok0.band == '0);
      ctl.load_ch    = tok0.ch;
      ctl.dly_re     = tok1_ff.vld && (tok1_ff.op == OP_B0 || tok1_ff.op == OP_B1);
      ctl.dly_raddr  = dly_addr(tok1_ff.ch, tok1_ff.band, tok1_ff.op == OP_B1);
      ctl.s1_gain    = (tok1_ff.op == OP_GAIN);
      ctl.s2_vld     = tok2_ff.vld;
      ctl.s2_op      = tok2_ff.op;
      ctl.s2_ch      = tok2_ff.ch;
      ctl.dly_we     = tok2_ff.vld && (tok2_ff.op == OP_A1 || tok2_ff.op == OP_A2);
      ctl.dly_waddr  = dly_addr(tok2_ff.ch, tok2_ff.band, tok2_ff.op == OP_A2);
      ctl.out_load   = (state_ff == S_FINISH) && out_free;
   end

`ifndef SYNTHESIS
   a_gain_ends_run: assert property (@(posedge clock) disable iff (reset)
      (tok2_ff.vld && tok2_ff.op == OP_GAIN && tok2_ff.ch) |=> (state_ff == S_FINISH))
      else $error("last gain step did not end the run");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!tok1_ff.vld && !tok2_ff.vld))
      else $error("steps still in flight while idle");

   a_y_load_clash: assert property (@(posedge clock) disable iff (reset)
      ctl.load_y |-> !(tok2_ff.vld && tok2_ff.op == OP_B1))
      else $error("channel load collides with a band output update");
`endif
endmodule

// File: src/sseq_dp.sv
// ----------------------------------------------------------------------------
// sseq_dp: shared MAC datapath of the stereo equalizer
// One multiplier with a registered product, rounding and saturation, the
// biquad partial sums and the per-channel result registers.
// ----------------------------------------------------------------------------
module sseq_dp import sseq_pkg::*; (
   input  logic                          clock,
   input  ctl_type                       ctl,
   input  logic signed [COEF_BITS-1:0]   coef_q,
   input  logic signed [DELAY_BITS-1:0]  dly_q,
   input  logic [GAIN_BITS-1:0]          gain,
   input  logic                          smp_load,
   input  logic signed [SAMPLE_BITS-1:0] left_in,
   input  logic signed [SAMPLE_BITS-1:0] right_in,
   output logic signed [DELAY_BITS-1:0]  dly_wdata,
   output logic signed [SAMPLE_BITS-1:0] chan_l,
   output logic signed [SAMPLE_BITS-1:0] chan_r
);
   localparam int PR_W = PROD_BITS + 1;
   localparam int WK_W = (PR_W > DELAY_BITS + 2) ? PR_W : DELAY_BITS + 2;

   typedef logic signed [WK_W-1:0]         wk_type;
   typedef logic signed [DELAY_BITS-1:0]   dly_type;
   typedef logic signed [DELAY_BITS:0]     acc_type;
   typedef logic signed [SAMPLE_BITS-1:0]  smp_type;

   localparam wk_type DLY_MAX = {{(WK_W - DELAY_BITS + 1){1'b0}}, {(DELAY_BITS - 1){1'b1}}};
   localparam wk_type DLY_MIN = ~DLY_MAX;
   localparam wk_type SMP_MAX = {{(WK_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam wk_type SMP_MIN = ~SMP_MAX;
   localparam wk_type PRD_RND = (PROD_SHIFT > 0) ? (wk_type'(1) <<< (PROD_SHIFT - 1))
                                                 : wk_type'(0);
   localparam wk_type Y_RND    = wk_type'(1) <<< (DELAY_FRAC - 1);
   localparam wk_type GAIN_RND = wk_type'(1) <<< (COEF_FRAC_BITS - 1);

   function automatic dly_type sat_dly(input wk_type v);
      dly_type r;
      if (v > DLY_MAX) r = DLY_MAX[DELAY_BITS-1:0];
      else if (v < DLY_MIN) r = DLY_MIN[DELAY_BITS-1:0];
      else r = v[DELAY_BITS-1:0];
      return r;
   endfunction

   function automatic smp_type sat_smp(input wk_type v);
      smp_type r;
      if (v > SMP_MAX) r = SMP_MAX[SAMPLE_BITS-1:0];
      else if (v < SMP_MIN) r = SMP_MIN[SAMPLE_BITS-1:0];
      else r = v[SAMPLE_BITS-1:0];
      return r;
   endfunction

   logic signed [COEF_BITS-1:0] mul_a;
   logic signed [PROD_BITS-1:0] prod_in, prod_ff;
   smp_type                     y_ff, y_in;
   dly_type                     yd_ff, yd_in;
   acc_type                     acc0_ff, acc0_in;
   dly_type                     acc1_ff, acc1_in;
   smp_type                     chan_l_ff, chan_l_in;
   smp_type                     chan_r_ff, chan_r_in;
   wk_type                      prod_wk;
   wk_type                      pv_wk;
   wk_type                      dq_wk;
   smp_type                     y_new;
   smp_type                     gained;

   // Multiply stage: the coefficient or the output gain times the running sample.
   assign mul_a   = ctl.s1_gain ? signed'({1'b0, gain}) : coef_q;
   assign prod_in = mul_a * y_ff;

   // Accumulate stage.
   assign prod_wk = wk_type'(prod_ff);
   assign pv_wk   = wk_type'(sat_dly((prod_wk + PRD_RND) >>> PROD_SHIFT));
   assign dq_wk   = wk_type'(dly_q);
   assign y_new   = sat_smp((wk_type'(yd_ff) + Y_RND) >>> DELAY_FRAC);
   assign gained  = sat_smp((-prod_wk + GAIN_RND) >>> COEF_FRAC_BITS);

   always_comb begin
      yd_in     = yd_ff;
      acc0_in   = acc0_ff;
      acc1_in   = acc1_ff;
      y_in      = y_ff;
      chan_l_in = chan_l_ff;
      chan_r_in = chan_r_ff;
      dly_wdata = sat_dly(wk_type'(acc1_ff) - pv_wk);

      if (ctl.s2_vld) begin
         case (ctl.s2_op)
            OP_B0: yd_in = sat_dly(pv_wk + dq_wk);
            OP_B1: begin
               acc0_in = acc_type'(pv_wk + dq_wk);
               y_in    = y_new;
            end
            OP_B2: acc1_in = pv_wk[DELAY_BITS-1:0];
            OP_A1: dly_wdata = sat_dly(wk_type'(acc0_ff) - pv_wk);
            OP_A2: dly_wdata = sat_dly(wk_type'(acc1_ff) - pv_wk);
            OP_GAIN: begin
               if (ctl.s2_ch) chan_r_in = gained;
               else chan_l_in = gained;
            end
            default: ;
         endcase
      end

      // A band chain starts from the stored channel sample.
      if (ctl.load_y) begin
         y_in = ctl.load_ch ? chan_r_ff : chan_l_ff;
      end

      if (smp_load) begin
         chan_l_in = left_in;
         chan_r_in = right_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      yd_ff     <= yd_in;
      acc0_ff   <= acc0_in;
      acc1_ff   <= acc1_in;
      y_ff      <= y_in;
      chan_l_ff <= chan_l_in;
      chan_r_ff <= chan_r_in;
   end

   assign chan_l = chan_l_ff;
   assign chan_r = chan_r_ff;
endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stereo seven-band biquad equalizer
// Drives sample pairs, coefficient writes and register writes with random
// idling on both channels. Every accepted result beat is compared with a
// bit-true prediction of the biquad cascade, the output gain and mono mode.
// ----------------------------------------------------------------------------
module tb import sseq_pkg::*;;

   // Run control. The settle wait covers one full pair with the filters on.
   // The cycle limit is several times the slowest legal run, including the
   // 57 percent stall patterns.
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 120;

   // Handy sample, coefficient and gain values.
   localparam int                            SMAX = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam int                            SMIN = -(1 << (SAMPLE_BITS - 1));
   localparam int                            CMAX = 32'h7fff_ffff;
   localparam int                            CMIN = 32'h8000_0000;
   localparam int                            COEF_ONE = 1 << COEF_FRAC_BITS;
   localparam logic [GAIN_BITS-1:0]          GAIN_MAX  = '1;
   localparam logic [GAIN_BITS-1:0]          GAIN_ZERO = '0;
   // A register index past the end of the register list; writes are dropped.
   localparam logic [CSR_IDX_BITS-1:0]       CSR_IDX_UNUSED = '1;
   // The highest slot code the field can carry, well past a2.
   localparam int                            SLOT_TOP = (1 << COEF_SLOT_BITS) - 1;

   // One beat on the input channel, unused fields included.
   typedef struct {
      bit                          operation;
      bit signed [SAMPLE_BITS-1:0] left;
      bit signed [SAMPLE_BITS-1:0] right;
      bit [COEF_BAND_BITS-1:0]     band;
      bit [COEF_SLOT_BITS-1:0]     slot;
      bit signed [COEF_BITS-1:0]   value;
   } eq_item_type;

   // One expected output pair.
   typedef struct {
      bit signed [SAMPLE_BITS-1:0] left;
      bit signed [SAMPLE_BITS-1:0] right;
   } eq_pair_type;

   // The scoreboard keeps its own copy of the registers, the coefficient
   // table and the delay words, and predicts each output pair as soon as the
   // matching input beat is accepted.
   class eq_checker;
      bit          filt_on;
      bit          mono_on;
      longint      out_gain;
      longint      coefs[COEF_DEPTH];
      longint      delays[DLY_DEPTH];
      eq_pair_type pending_pairs[$];
      int          errors;
      int          pairs_checked;
      int          coef_writes;
      int          reg_writes;

      function new();
         filt_on  = 1'b0;
         mono_on  = 1'b0;
         out_gain = longint'(GAIN_RESET);
         foreach (coefs[i]) coefs[i] = 0;
         foreach (delays[i]) delays[i] = 0;
         errors        = 0;
         pairs_checked = 0;
         coef_writes   = 0;
         reg_writes    = 0;
      endfunction

      function longint clamp(longint v, int w);
         longint hi = (64'sd1 <<< (w - 1)) - 1;
         longint lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      // Shift right with rounding to nearest, ties toward plus infinity.
      function longint shift_round(longint v, int s);
         return (v + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      function longint product(longint c, longint v);
         return clamp(shift_round(c * v, PROD_SHIFT), DELAY_BITS);
      endfunction

      // Runs one channel through every band and updates its delay words.
      function longint filter_channel(longint x, int ch);
         longint yd;
         longint y;
         int     base;
         int     di;
         for (int b = 0; b < BANDS; b++) begin
            base = b * NUM_SLOTS;
            di   = (ch * BANDS + b) * 2;
            yd = clamp(product(coefs[base + OP_B0], x) + delays[di], DELAY_BITS);
            y  = clamp(shift_round(yd, DELAY_FRAC), SAMPLE_BITS);
            delays[di] = clamp(product(coefs[base + OP_B1], x)
                               - product(coefs[base + OP_A1], y) + delays[di + 1],
                               DELAY_BITS);
            delays[di + 1] = clamp(product(coefs[base + OP_B2], x)
                                   - product(coefs[base + OP_A2], y), DELAY_BITS);
            x = y;
         end
         return x;
      endfunction

      function longint gain_stage(longint y);
         return clamp(shift_round(-(y * out_gain), COEF_FRAC_BITS), SAMPLE_BITS);
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [GAIN_BITS-1:0] wdata);
         reg_writes++;
         case (idx)
            CSR_EQ_ENABLE:   filt_on  = wdata[0];
            CSR_MONO_MODE:   mono_on  = wdata[0];
            CSR_OUTPUT_GAIN: out_gain = longint'(wdata);
            default: ;
         endcase
      endfunction

      function void note_item(eq_item_type it);
         longint      l;
         longint      r;
         eq_pair_type e;
         if (it.operation == OPER_COEF) begin
            if (it.band < BANDS && it.slot < NUM_SLOTS) begin
               coefs[it.band * NUM_SLOTS + it.slot] = longint'(it.value);
               coef_writes++;
            end
         end else begin
            l = longint'(it.left);
            r = longint'(it.right);
            if (filt_on) begin
               l = gain_stage(filter_channel(l, 0));
               r = gain_stage(filter_channel(r, 1));
            end
            if (mono_on) r = l;
            e.left  = l[SAMPLE_BITS-1:0];
            e.right = r[SAMPLE_BITS-1:0];
            pending_pairs.push_back(e);
         end
      endfunction

      function void check_pair(logic signed [SAMPLE_BITS-1:0] l,
                               logic signed [SAMPLE_BITS-1:0] r);
         eq_pair_type e;
         if (pending_pairs.size() == 0) begin
            errors++;
            $display("%0t: result beat with no pair outstanding: left %0d right %0d",
                     $time, l, r);
            return;
         end
         e = pending_pairs.pop_front();
         pairs_checked++;
         if (l !== e.left) begin
            errors++;
            $display("%0t: left_out mismatch: expected %0d, actual %0d", $time, e.left, l);
         end
         if (r !== e.right) begin
            errors++;
            $display("%0t: right_out mismatch: expected %0d, actual %0d", $time, e.right, r);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_gap_pct;
   int   recv_stall_pct;
   int   cycle_count = 0;

   eq_checker sb = new();

   sseq_req_if req_bus ();
   sseq_rsp_if rsp_bus ();
   sseq_csr_if csr_bus ();

   stereo_seven_band_biquad_eq uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The watchdog ends a run that hangs. It is the only other way out.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Watchdog expired after %0d cycles.", cycle_count);
         $display("** stereo_seven_band_biquad_eq: FAILED **");
         $finish;
      end
   end

   // Result side. A beat is taken at an edge where valid and ready were both
   // high just before it; ready is then redrawn for the next edge, which
   // gives the receiver its random stalls.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_pair(rsp_bus.left_out, rsp_bus.right_out);
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Fills every field with noise so that unused fields toggle too.
   function automatic eq_item_type random_fill();
      eq_item_type it;
      it.operation = 1'($urandom);
      it.left      = SAMPLE_BITS'($urandom);
      it.right     = SAMPLE_BITS'($urandom);
      it.band      = COEF_BAND_BITS'($urandom);
      it.slot      = COEF_SLOT_BITS'($urandom);
      it.value     = $urandom;
      return it;
   endfunction

   function automatic eq_item_type make_pair(int l, int r);
      eq_item_type it = random_fill();
      it.operation = OPER_SAMPLE;
      it.left      = SAMPLE_BITS'(l);
      it.right     = SAMPLE_BITS'(r);
      return it;
   endfunction

   function automatic eq_item_type make_coef(int band, int slot, int value);
      eq_item_type it = random_fill();
      it.operation = OPER_COEF;
      it.band      = COEF_BAND_BITS'(band);
      it.slot      = COEF_SLOT_BITS'(slot);
      it.value     = value;
      return it;
   endfunction

   function automatic int extreme_sample();
      case ($urandom_range(0, 3))
         0:       return SMAX;
         1:       return SMIN;
         2:       return 0;
         default: return -1;
      endcase
   endfunction

   // Mostly full-scale random samples, some quiet ones, a few at the rails or at 0 and -1.
   function automatic eq_item_type random_pair();
      int pick = $urandom_range(0, 9);
      if (pick < 6)
         return make_pair($urandom, $urandom);
      if (pick < 9)
         return make_pair(int'($urandom_range(0, 131072)) - 65536,
                          int'($urandom_range(0, 131072)) - 65536);
      return make_pair(extreme_sample(), extreme_sample());
   endfunction

   // Presents one beat, possibly after a random gap, and holds it until the
   // block takes it. Valid is left high on return; the next call or the
   // drain task drives it in the same step, so no beat is offered twice.
   task automatic send_item(input eq_item_type it);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= it.operation;
      req_bus.left_sample  <= it.left;
      req_bus.right_sample <= it.right;
      req_bus.coef_band    <= it.band;
      req_bus.coef_slot    <= it.slot;
      req_bus.coef_value   <= it.value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_item(it);
   endtask

   // Stops sending and waits until every predicted pair has come back, then
   // lets the block settle so a trailing coefficient write has landed too.
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      while (sb.pending_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [GAIN_BITS-1:0] wdata);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= wdata;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.write_reg(idx, wdata);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Registers only change while the block is idle.
   task automatic apply_settings(input bit en, input bit mono,
                                 input logic [GAIN_BITS-1:0] gain);
      drain_block();
      write_csr(CSR_EQ_ENABLE, GAIN_BITS'(en));
      write_csr(CSR_MONO_MODE, GAIN_BITS'(mono));
      write_csr(CSR_OUTPUT_GAIN, gain);
   endtask

   // Loads all bands. A gentle set sits near unity pass-through; a wide set
   // uses full-range values and drives the chain into saturation.
   task automatic load_filter_set(input bit wide);
      int v;
      for (int b = 0; b < BANDS; b++) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (wide)
               v = $urandom;
            else if (s == OP_B0)
               v = COEF_ONE + int'($urandom_range(0, 1 << 27)) - (1 << 26);
            else
               v = int'($urandom_range(0, 1 << 27)) - (1 << 26);
            send_item(make_coef(b, s, v));
         end
      end
   endtask

   initial begin
      int          pick;
      int          phase;
      logic [GAIN_BITS-1:0] gain;

      reset                = 1'b1;
      send_gap_pct         = 7;
      recv_stall_pct       = 57;
      req_bus.valid        = 1'b0;
      req_bus.operation    = OPER_SAMPLE;
      req_bus.left_sample  = '0;
      req_bus.right_sample = '0;
      req_bus.coef_band    = '0;
      req_bus.coef_slot    = '0;
      req_bus.coef_value   = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_EQ_ENABLE;
      csr_bus.data         = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed part. Out of reset the filters are bypassed, so the rails
      // must come straight through.
      send_item(make_pair(SMAX, SMIN));
      send_item(make_pair(SMIN, SMAX));
      send_item(make_pair(0, -1));
      send_item(make_pair(1, SMAX - 1));

      // Mono mode copies left onto right even in bypass.
      apply_settings(1'b0, 1'b1, GAIN_RESET);
      send_item(make_pair(12345, -54321));

      // Filters on with an all-zero table: the chain outputs zero.
      apply_settings(1'b1, 1'b0, GAIN_RESET);
      send_item(make_pair(SMAX, SMIN));

      // Writes past the last band or the last slot must be dropped, so the
      // output stays at zero.
      send_item(make_coef(BANDS, OP_B0, CMAX));
      send_item(make_coef(0, NUM_SLOTS, CMAX));
      send_item(make_coef(BANDS - 1, SLOT_TOP, -1));
      send_item(make_pair(SMIN, SMAX));

      // Unity b0 everywhere: the output is the negated input, and the
      // negative rail saturates to the positive one.
      for (int b = 0; b < BANDS; b++) send_item(make_coef(b, OP_B0, COEF_ONE));
      send_item(make_pair(SMAX, SMIN));

      // Extreme coefficients push the band output and delay words to the rails.
      send_item(make_coef(3, OP_B0, CMAX));
      send_item(make_coef(0, OP_B1, CMIN));
      send_item(make_pair(32'sh0010_0000, -32'sh0010_0000));

      // Largest and zero output gain.
      apply_settings(1'b1, 1'b1, GAIN_MAX);
      send_item(make_pair(SMAX, 1));
      apply_settings(1'b1, 1'b0, GAIN_ZERO);
      send_item(make_pair(SMIN, SMAX));

      // Random part: three idle patterns, four setting phases each. Most
      // beats are sample pairs through a freshly loaded filter set; the rest
      // are stray coefficient writes with any band, slot and value.
      phase = 0;
      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0:       begin send_gap_pct = 7;  recv_stall_pct = 57; end
            1:       begin send_gap_pct = 57; recv_stall_pct = 7;  end
            default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
         endcase
         for (int q = 0; q < PHASES / 3; q++) begin
            case (phase % 4)
               0:       gain = GAIN_RESET;
               1:       gain = GAIN_MAX;
               2:       gain = GAIN_ZERO;
               default: gain = GAIN_BITS'($urandom_range(0, 1 << 29));
            endcase
            apply_settings(phase != 5 && phase != 10, phase % 2 == 1, gain);
            // A write to an index past the register list changes nothing.
            write_csr(CSR_IDX_UNUSED, GAIN_BITS'($urandom));
            if (q == 0 || $urandom_range(0, 9) < 6)
               load_filter_set($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
               pick = $urandom_range(0, 99);
               if (pick < 6) begin
                  send_item(make_coef($urandom, $urandom, $urandom));
               end else begin
                  send_item(random_pair());
               end
            end
            phase++;
         end
      end

      drain_block();
      if (sb.pending_pairs.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d predicted pairs never arrived", $time, sb.pending_pairs.size());
      end

      $display("Run covered %0d checked pairs, %0d coefficient loads and %0d register writes,",
               sb.pairs_checked, sb.coef_writes, sb.reg_writes);
      $display("across %0d setting phases and three idle patterns, with %0d errors.",
               phase, sb.errors);
      if (sb.errors == 0) begin
         $display("** stereo_seven_band_biquad_eq: PASSED **");
      end else begin
         $display("** stereo_seven_band_biquad_eq: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/sseq_pkg.sv
src/sseq_req_if.sv
src/sseq_rsp_if.sv
src/sseq_csr_if.sv
src/sseq_ram.sv
src/sseq_seq.sv
src/sseq_dp.sv
src/stereo_seven_band_biquad_eq.sv
tb/sv/tb.sv
